// ----- hdl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers, compiled away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Check that an expression holds on every clock edge out of reset
`define ASSERT_ALWAYS(lbl, clk, rst, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);
// Check that a consequent holds in the cycle of its antecedent
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Check that a consequent holds in the cycle after its antecedent
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define ASSERT_ALWAYS(lbl, clk, rst, expr, msg)
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons, msg)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif

`endif

// ----- hdl/pidc_pkg.sv -----
// ----------------------------------------------------------------------------
// PID controller package
// Shared types, register indexes, codes and saturation helper.
// ----------------------------------------------------------------------------
package pidc_pkg;

  // Accumulator width for the three-product sum (exact, needs 49 bits)
  localparam int ACC_W = 50;
  // Width of the floored drive value (accumulator shifted right by 8)
  localparam int DRV_W = ACC_W - 8;
  // Working width for saturating arithmetic
  localparam int EXT_W = 44;

  localparam logic signed [31:0] I32_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] I32_MIN = 32'sh8000_0000;

  // Configuration register indexes
  localparam logic [2:0] CFG_GAIN_P    = 3'd0;
  localparam logic [2:0] CFG_GAIN_I    = 3'd1;
  localparam logic [2:0] CFG_GAIN_D    = 3'd2;
  localparam logic [2:0] CFG_DRIVE_MAX = 3'd3;
  localparam logic [2:0] CFG_DRIVE_MIN = 3'd4;

  // Clamp status codes
  typedef enum logic [1:0] {
    CLAMP_NONE = 2'd0,
    CLAMP_HIGH = 2'd1,
    CLAMP_LOW  = 2'd2
  } clamp_t;

  // Operand pair for the shared multiplier
  typedef enum logic [1:0] {
    MSEL_P = 2'd0,
    MSEL_I = 2'd1,
    MSEL_D = 2'd2
  } mul_sel_t;

  // Configuration registers (all two's complement Q8.8)
  typedef struct packed {
    logic [15:0] gain_p;
    logic [15:0] gain_i;
    logic [15:0] gain_d;
    logic [15:0] drive_max;
    logic [15:0] drive_min;
  } cfg_t;

  // Controller to datapath commands
  typedef struct packed {
    logic     load;
    logic     div_start;
    logic     sign_fix;
    logic     mul_en;
    mul_sel_t mul_sel;
    logic     acc_clear;
    logic     acc_sub;
    logic     compare;
    logic     update;
  } dp_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic zero_step;
    logic div_done;
  } dp_sts_t;

  // Saturate a wide signed value to the signed 32-bit range
  function automatic logic signed [31:0] sat32(input logic signed [EXT_W-1:0] v);
    logic signed [31:0] r;
    if (v > EXT_W'(I32_MAX)) begin
      r = I32_MAX;
    end else if (v < EXT_W'(I32_MIN)) begin
      r = I32_MIN;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

// ----- hdl/pidc_div.sv -----
// ----------------------------------------------------------------------------
// Restoring divider
// Unsigned 32 by 16 bit division, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module pidc_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] dividend,
  input  logic [15:0] divisor,
  output logic        done,
  output logic [31:0] quotient
);

  logic        busy;
  logic [4:0]  count;
  logic [15:0] rem;
  logic [16:0] trial;
  logic        fits;

  // Shift in the next dividend bit and test against the divisor
  assign trial = {rem, quotient[31]};
  assign fits  = trial >= {1'b0, divisor};

  // Control: run for 32 steps, pulse done after the last
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        count <= '0;
      end else if (busy) begin
        count <= count + 5'd1;
        if (count == 5'd31) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath: remainder and quotient shift register
  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= '0;
      quotient <= dividend;
    end else if (busy) begin
      rem      <= fits ? 16'(trial - {1'b0, divisor}) : trial[15:0];
      quotient <= {quotient[30:0], fits};
    end
  end

endmodule

// ----- hdl/pidc_dpath.sv -----
// ----------------------------------------------------------------------------
// PID datapath
// Derivative, integral, shared multiplier, accumulator, clamp and outputs.
// ----------------------------------------------------------------------------
module pidc_dpath (
  input  logic              clk,
  input  logic              rst,
  input  pidc_pkg::cfg_t    cfg,
  input  logic [15:0]       error_sample,
  input  logic [15:0]       time_step,
  input  pidc_pkg::dp_cmd_t cmd,
  output pidc_pkg::dp_sts_t sts,
  output logic [15:0]       drive,
  output logic [1:0]        clamp_state,
  output logic              zero_step
);

  import pidc_pkg::*;

  // Loop state
  logic signed [15:0] previous_error;
  logic signed [31:0] error_integral;

  // Per-sample working registers
  logic signed [15:0] err;
  logic [15:0]        time_step_r;
  logic               zero_r;
  logic               diff_neg;
  logic [15:0]        diff_mag;
  logic signed [31:0] integ;
  logic signed [31:0] deriv;
  logic signed [47:0] prod;
  logic signed [ACC_W-1:0] acc;
  logic signed [31:0] overshoot;
  logic [15:0]        drive_val;
  clamp_t             clamp_r;

  // Combinational helpers
  logic signed [16:0] diff;
  logic [31:0]        quot;
  logic               div_done;
  logic signed [15:0] mul_a;
  logic signed [31:0] mul_b;
  logic signed [EXT_W-1:0] quot_ext;
  logic signed [DRV_W-1:0] drv;
  logic signed [DRV_W-1:0] hi;
  logic signed [DRV_W-1:0] lo;

  assign diff = 17'(signed'(error_sample)) - 17'(previous_error);

  // Divider for (diff * 65536) / dt on magnitudes
  pidc_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend ({diff_mag, 16'h0000}),
    .divisor  (time_step_r),
    .done     (div_done),
    .quotient (quot)
  );

  assign sts.zero_step = zero_r;
  assign sts.div_done  = div_done;

  // Loop state: update previous error on load, integral after clamp
  always_ff @(posedge clk) begin
    if (rst) begin
      previous_error <= '0;
      error_integral <= '0;
    end else begin
      if (cmd.load) begin
        previous_error <= signed'(error_sample);
      end
      if (cmd.update) begin
        case (clamp_r)
          CLAMP_HIGH: error_integral <= sat32(EXT_W'(integ) - EXT_W'(overshoot));
          CLAMP_LOW:  error_integral <= sat32(EXT_W'(integ) + EXT_W'(overshoot));
          default:    error_integral <= integ;
        endcase
      end
    end
  end

  // Capture the sample, difference magnitude and updated integral
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      err         <= signed'(error_sample);
      time_step_r <= time_step;
      zero_r      <= (time_step == 16'h0000);
      diff_neg    <= diff[16];
      diff_mag    <= diff[16] ? 16'(-diff) : diff[15:0];
      integ       <= sat32(EXT_W'(error_integral) + EXT_W'(signed'(error_sample)));
    end
  end

  // Apply sign to the quotient and saturate; zero step forces zero
  assign quot_ext = signed'({12'h000, quot});

  always_ff @(posedge clk) begin
    if (cmd.sign_fix) begin
      if (zero_r) begin
        deriv <= '0;
      end else begin
        deriv <= sat32(diff_neg ? -quot_ext : quot_ext);
      end
    end
  end

  // Select operands for the shared multiplier
  always_comb begin
    case (cmd.mul_sel)
      MSEL_P: begin
        mul_a = signed'(cfg.gain_p);
        mul_b = 32'(err);
      end
      MSEL_I: begin
        mul_a = signed'(cfg.gain_i);
        mul_b = integ;
      end
      MSEL_D: begin
        mul_a = signed'(cfg.gain_d);
        mul_b = deriv;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Register each product and subtract it from the sum in the next cycle
  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      prod <= mul_a * mul_b;
    end
    if (cmd.acc_clear) begin
      acc <= '0;
    end else if (cmd.acc_sub) begin
      acc <= acc - ACC_W'(prod);
    end
  end

  // Floor to Q.8 and compare with limits; upper limit has priority
  assign drv = signed'(acc[ACC_W-1:8]);
  assign hi  = DRV_W'(signed'(cfg.drive_max));
  assign lo  = DRV_W'(signed'(cfg.drive_min));

  always_ff @(posedge clk) begin
    if (cmd.compare) begin
      if (drv > hi) begin
        clamp_r   <= CLAMP_HIGH;
        overshoot <= sat32(EXT_W'(drv) - EXT_W'(hi));
        drive_val <= cfg.drive_max;
      end else if (drv < lo) begin
        clamp_r   <= CLAMP_LOW;
        overshoot <= sat32(EXT_W'(lo) - EXT_W'(drv));
        drive_val <= cfg.drive_min;
      end else begin
        clamp_r   <= CLAMP_NONE;
        overshoot <= '0;
        drive_val <= drv[15:0];
      end
    end
  end

  // Output register, loaded once the previous beat has left
  always_ff @(posedge clk) begin
    if (cmd.update) begin
      drive       <= drive_val;
      clamp_state <= clamp_r;
      zero_step   <= zero_r;
    end
  end

endmodule

// ----- hdl/pidc_ctrl.sv -----
// ----------------------------------------------------------------------------
// PID controller sequencer
// Steps the datapath through divide (skipped on a zero time step), multiply, clamp and output.
// ----------------------------------------------------------------------------
module pidc_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output pidc_pkg::dp_cmd_t cmd,
  input  pidc_pkg::dp_sts_t sts
);

  import pidc_pkg::*;

  typedef enum logic [9:0] {
    S_IDLE  = 10'b00_0000_0001,
    S_START = 10'b00_0000_0010,
    S_DIV   = 10'b00_0000_0100,
    S_SIGN  = 10'b00_0000_1000,
    S_MUL_P = 10'b00_0001_0000,
    S_MUL_I = 10'b00_0010_0000,
    S_MUL_D = 10'b00_0100_0000,
    S_ACC   = 10'b00_1000_0000,
    S_CMP   = 10'b01_0000_0000,
    S_UPD   = 10'b10_0000_0000
  } state_t;

  state_t state;
  state_t state_next;
  logic   out_free;

  assign in_ready = (state == S_IDLE);
  assign out_free = !out_valid || out_ready;

  // Next state and commands
  always_comb begin
    state_next    = state;
    cmd           = '0;
    cmd.mul_sel   = MSEL_P;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_START;
        end
      end
      S_START: begin
        if (sts.zero_step) begin
          state_next = S_SIGN;
        end else begin
          cmd.div_start = 1'b1;
          state_next    = S_DIV;
        end
      end
      S_DIV: begin
        if (sts.div_done) begin
          state_next = S_SIGN;
        end
      end
      S_SIGN: begin
        cmd.sign_fix = 1'b1;
        state_next   = S_MUL_P;
      end
      S_MUL_P: begin
        cmd.mul_en    = 1'b1;
        cmd.mul_sel   = MSEL_P;
        cmd.acc_clear = 1'b1;
        state_next    = S_MUL_I;
      end
      S_MUL_I: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MSEL_I;
        cmd.acc_sub = 1'b1;
        state_next  = S_MUL_D;
      end
      S_MUL_D: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MSEL_D;
        cmd.acc_sub = 1'b1;
        state_next  = S_ACC;
      end
      S_ACC: begin
        cmd.acc_sub = 1'b1;
        state_next  = S_CMP;
      end
      S_CMP: begin
        cmd.compare = 1'b1;
        state_next  = S_UPD;
      end
      S_UPD: begin
        // Hold until the output register is free
        if (out_free) begin
          cmd.update = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // State and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.update) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ----- hdl/pid_controller_antiwindup_top.sv -----
// ----------------------------------------------------------------------------
// PID controller with output clamp and integral anti-windup
// Top level: configuration registers, sequencer and datapath.
// ----------------------------------------------------------------------------
// One sample is processed at a time. The derivative is formed by the
// one-bit-per-cycle divider (32 steps); a sample with a zero time step
// skips the divider. The three gain products share one 16x32
// multiplier, one product per cycle. The result sits in an output
// register, so the next sample is taken while it waits for out_ready.
// Configuration writes land at once and must only be issued while no
// sample is in flight.

`include "assert_macros.svh"

module pid_controller_antiwindup_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [15:0] error_sample,
  input  logic [15:0] time_step,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] drive,
  output logic [1:0]  clamp_state,
  output logic        zero_step
);

  import pidc_pkg::*;

  cfg_t    cfg;
  dp_cmd_t dp_cmd;
  dp_sts_t dp_sts;

  // Configuration registers; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.gain_p    <= 16'h0000;
      cfg.gain_i    <= 16'h0000;
      cfg.gain_d    <= 16'h0000;
      cfg.drive_max <= 16'h7FFF;
      cfg.drive_min <= 16'h8000;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_GAIN_P:    cfg.gain_p    <= cfg_data;
        CFG_GAIN_I:    cfg.gain_i    <= cfg_data;
        CFG_GAIN_D:    cfg.gain_d    <= cfg_data;
        CFG_DRIVE_MAX: cfg.drive_max <= cfg_data;
        CFG_DRIVE_MIN: cfg.drive_min <= cfg_data;
        default: ;
      endcase
    end
  end

  pidc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (dp_cmd),
    .sts       (dp_sts)
  );

  pidc_dpath u_dpath (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .error_sample (error_sample),
    .time_step    (time_step),
    .cmd          (dp_cmd),
    .sts          (dp_sts),
    .drive        (drive),
    .clamp_state  (clamp_state),
    .zero_step    (zero_step)
  );

  // One sample at a time: no accept in the cycle after an accept
  `ASSERT_NEXT(a_one_in_flight, clk, rst, in_valid && in_ready, !in_ready, "second beat accepted while busy")
  // A new result beat only comes from an output register load
  `ASSERT_IMPLIES(a_out_from_update, clk, rst, $rose(out_valid), $past(dp_cmd.update), "result beat without output load")
  // The divider is never started on a zero time step
  `ASSERT_IMPLIES(a_no_div_by_zero, clk, rst, dp_cmd.div_start, !dp_sts.zero_step, "divider started with zero time step")
  // The output register is never loaded over a waiting beat
  `ASSERT_IMPLIES(a_no_overwrite, clk, rst, dp_cmd.update, !out_valid || out_ready, "waiting result beat overwritten")

endmodule
